// ----- rtl/core/vau_pkg.sv -----
// ----------------------------------------------------------------------------
// vau_pkg: shared types and constants of the vector angle unit
// Internal widths, the CORDIC arctangent table and the stage control struct.
// ----------------------------------------------------------------------------
package vau_pkg;

  localparam int COMPONENT_BITS_DEF  = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 14;

  // internal component width after the input pre-shift
  localparam int COMP_W     = 16;
  localparam int PROD_W     = 2 * COMP_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int CRS_W      = 64;
  localparam int DMAG_W     = 32;
  localparam int XY_W       = 36;
  localparam int Z_W        = 34;
  localparam int INNER_FRAC = 30;

  localparam int NORM_CELLS   = 5;
  localparam int SQRT_CELLS   = 32;
  localparam int CORDIC_CELLS = 30;

  localparam logic [Z_W-1:0] PI_Q30      = 34'd3373259426;
  localparam logic [Z_W-1:0] HALF_PI_Q30 = 34'd1686629713;

  // per-stage control travelling beside the data
  typedef struct packed {
    logic valid;
    logic degen;
    logic neg;
  } ctl_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = 34'sd843314857;
      1:       v = 34'sd497837829;
      2:       v = 34'sd263043837;
      3:       v = 34'sd133525159;
      4:       v = 34'sd67021687;
      5:       v = 34'sd33543516;
      6:       v = 34'sd16775851;
      7:       v = 34'sd8388437;
      8:       v = 34'sd4194283;
      9:       v = 34'sd2097149;
      10:      v = 34'sd1048576;
      default: v = 34'sd1 <<< (INNER_FRAC - i);
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/vector_angle_unit.sv -----
// ----------------------------------------------------------------------------
// vector_angle_unit: angle between two 3D vectors
// Pipelined atan2(|a x b|, a . b), result in radians Q2.14 from 0 to pi.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transaction carries both vectors, six signed
//   components of COMPONENT_BITS each (Q8.8 at the default width). For 2D
//   work drive both z components with zero.
//   Output stream: one transaction per input transaction, in order. tdata
//   holds the angle (unsigned, ANGLE_FRAC_BITS fraction bits, 0 to pi),
//   tuser flags a zero-length vector; the angle is then 0.
//   Throughput: one transaction per cycle while the output is not stalled.
//   The chain holds 4 product stages, 5 normalize cells, 32 square-root
//   cells, one quadrant stage, 30 CORDIC cells and the output register.
//   Stall: while a result waits in the output register the chain keeps
//   moving as long as its last cell holds a bubble; only when a finished
//   result would collide does the whole chain hold and in_tready drop.
//   Reset: synchronous, active low; all valid bits clear, nothing is in
//   flight afterward.
// ----------------------------------------------------------------------------
module vector_angle_unit #(
  parameter int COMPONENT_BITS  = vau_pkg::COMPONENT_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = vau_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // ax, ay, az, bx, by, bz from the lowest bit up, zero padded to bytes
  input  logic [((6*COMPONENT_BITS+7)/8)*8-1:0]  in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // angle, zero padded to bytes
  output logic [((ANGLE_FRAC_BITS+2+7)/8)*8-1:0] out_tdata,
  // degenerate
  output logic                                   out_tuser
);

  localparam int CB      = COMPONENT_BITS;
  localparam int AW      = ANGLE_FRAC_BITS + 2;
  localparam int OUT_W   = ((AW + 7) / 8) * 8;
  localparam int RSH     = vau_pkg::INNER_FRAC - ANGLE_FRAC_BITS;
  localparam int CW      = vau_pkg::COMP_W;
  localparam int PW      = vau_pkg::PROD_W;
  localparam int ZW      = vau_pkg::Z_W;
  localparam int XYW     = vau_pkg::XY_W;
  localparam logic [ZW-1:0] RND    = 34'd1 << (RSH - 1);
  localparam logic [ZW-1:0] PI_OUT = (vau_pkg::PI_Q30 + RND) >> RSH;

  logic en;

  // ---- input: pre-shift each component to the internal width
  logic signed [CW-1:0] comp [0:5];
  logic                 a_zero, b_zero;

  genvar gi;
  generate
    for (gi = 0; gi < 6; gi++) begin : g_comp
      if (CB > CW) begin : g_wide
        assign comp[gi] = in_tdata[gi*CB + CB - 1 -: CW];
      end else begin : g_narrow
        assign comp[gi] = CW'(signed'(in_tdata[gi*CB +: CB]));
      end
    end
  endgenerate

  assign a_zero = (comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0);
  assign b_zero = (comp[3] == '0) && (comp[4] == '0) && (comp[5] == '0);

  // ---- stage 1: nine partial products
  vau_pkg::ctl_t        s1_ctl_r;
  logic signed [PW-1:0] p_r [0:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r <= '{valid: in_tvalid, degen: a_zero || b_zero, neg: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= comp[0] * comp[3];  // ax*bx
      p_r[1] <= comp[1] * comp[4];  // ay*by
      p_r[2] <= comp[2] * comp[5];  // az*bz
      p_r[3] <= comp[1] * comp[5];  // ay*bz
      p_r[4] <= comp[2] * comp[4];  // az*by
      p_r[5] <= comp[2] * comp[3];  // az*bx
      p_r[6] <= comp[0] * comp[5];  // ax*bz
      p_r[7] <= comp[0] * comp[4];  // ax*by
      p_r[8] <= comp[1] * comp[3];  // ay*bx
    end
  end

  // ---- stage 2: dot product and cross components
  vau_pkg::ctl_t                      s2_ctl_r;
  logic signed [vau_pkg::DOT_W-1:0]   dot_r;
  logic signed [vau_pkg::CROSS_W-1:0] c_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (en) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r  <= vau_pkg::DOT_W'(p_r[0]) + vau_pkg::DOT_W'(p_r[1]) + vau_pkg::DOT_W'(p_r[2]);
      c_r[0] <= vau_pkg::CROSS_W'(p_r[3]) - vau_pkg::CROSS_W'(p_r[4]);
      c_r[1] <= vau_pkg::CROSS_W'(p_r[5]) - vau_pkg::CROSS_W'(p_r[6]);
      c_r[2] <= vau_pkg::CROSS_W'(p_r[7]) - vau_pkg::CROSS_W'(p_r[8]);
    end
  end

  // ---- stage 3: squares of the cross components, dot magnitude and sign
  vau_pkg::ctl_t                   s3_ctl_r;
  logic [vau_pkg::CRS_W-1:0]       sq_r [0:2];
  logic [vau_pkg::DMAG_W-1:0]      s3_dmag_r;
  logic [31:0]                     cabs [0:2];
  logic [vau_pkg::DMAG_W-1:0]      dabs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cabs[i] = c_r[i][vau_pkg::CROSS_W-1] ? 32'(-c_r[i]) : 32'(c_r[i]);
    end
    dabs = dot_r[vau_pkg::DOT_W-1] ? vau_pkg::DMAG_W'(-dot_r) : vau_pkg::DMAG_W'(dot_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else if (en) begin
      s3_ctl_r <= '{valid: s2_ctl_r.valid, degen: s2_ctl_r.degen,
                    neg: dot_r[vau_pkg::DOT_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 64'(cabs[i]) * 64'(cabs[i]);
      end
      s3_dmag_r <= dabs;
    end
  end

  // ---- stage 4: squared cross length
  vau_pkg::ctl_t              s4_ctl_r;
  logic [vau_pkg::CRS_W-1:0]  s4_crs_r;
  logic [vau_pkg::DMAG_W-1:0] s4_dmag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else if (en) begin
      s4_ctl_r <= s3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_crs_r  <= sq_r[0] + sq_r[1] + sq_r[2];
      s4_dmag_r <= s3_dmag_r;
    end
  end

  // ---- normalize: shift by 16, 8, 4, 2, 1 steps where the limits allow
  vau_pkg::ctl_t              n_ctl  [0:vau_pkg::NORM_CELLS];
  logic [vau_pkg::CRS_W-1:0]  n_crs  [0:vau_pkg::NORM_CELLS];
  logic [vau_pkg::DMAG_W-1:0] n_dmag [0:vau_pkg::NORM_CELLS];

  assign n_ctl[0]  = s4_ctl_r;
  assign n_crs[0]  = s4_crs_r;
  assign n_dmag[0] = s4_dmag_r;

  generate
    for (gi = 0; gi < vau_pkg::NORM_CELLS; gi++) begin : g_norm
      vau_norm_cell #(
        .SHIFT (1 << (vau_pkg::NORM_CELLS - 1 - gi))
      ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_i  (n_ctl[gi]),
        .crs_i  (n_crs[gi]),
        .dmag_i (n_dmag[gi]),
        .ctl_o  (n_ctl[gi+1]),
        .crs_o  (n_crs[gi+1]),
        .dmag_o (n_dmag[gi+1])
      );
    end
  endgenerate

  // ---- square root of the scaled cross length, one root bit per cell
  vau_pkg::ctl_t              q_ctl  [0:vau_pkg::SQRT_CELLS];
  logic [vau_pkg::CRS_W-1:0]  q_rem  [0:vau_pkg::SQRT_CELLS];
  logic [vau_pkg::CRS_W-1:0]  q_root [0:vau_pkg::SQRT_CELLS];
  logic [vau_pkg::DMAG_W-1:0] q_dmag [0:vau_pkg::SQRT_CELLS];

  assign q_ctl[0]  = n_ctl[vau_pkg::NORM_CELLS];
  assign q_rem[0]  = n_crs[vau_pkg::NORM_CELLS];
  assign q_root[0] = '0;
  assign q_dmag[0] = n_dmag[vau_pkg::NORM_CELLS];

  generate
    for (gi = 0; gi < vau_pkg::SQRT_CELLS; gi++) begin : g_sqrt
      vau_sqrt_cell #(
        .STEP (gi)
      ) u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_i  (q_ctl[gi]),
        .rem_i  (q_rem[gi]),
        .root_i (q_root[gi]),
        .dmag_i (q_dmag[gi]),
        .ctl_o  (q_ctl[gi+1]),
        .rem_o  (q_rem[gi+1]),
        .root_o (q_root[gi+1]),
        .dmag_o (q_dmag[gi+1])
      );
    end
  endgenerate

  // ---- quadrant: for a negative dot turn by -pi/2 and start at pi/2
  vau_pkg::ctl_t         pr_ctl_r;
  logic signed [XYW-1:0] pr_x_r, pr_y_r;
  logic signed [ZW-1:0]  pr_z_r;
  logic signed [XYW-1:0] yroot, xdot;

  assign yroot = signed'(XYW'(q_root[vau_pkg::SQRT_CELLS]));
  assign xdot  = signed'(XYW'(q_dmag[vau_pkg::SQRT_CELLS]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_ctl_r <= '0;
    end else if (en) begin
      pr_ctl_r <= q_ctl[vau_pkg::SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (q_ctl[vau_pkg::SQRT_CELLS].neg) begin
        pr_x_r <= yroot;
        pr_y_r <= xdot;
        pr_z_r <= signed'(vau_pkg::HALF_PI_Q30);
      end else begin
        pr_x_r <= xdot;
        pr_y_r <= yroot;
        pr_z_r <= '0;
      end
    end
  end

  // ---- CORDIC vectoring chain
  vau_pkg::ctl_t         k_ctl [0:vau_pkg::CORDIC_CELLS];
  logic signed [XYW-1:0] k_x   [0:vau_pkg::CORDIC_CELLS];
  logic signed [XYW-1:0] k_y   [0:vau_pkg::CORDIC_CELLS];
  logic signed [ZW-1:0]  k_z   [0:vau_pkg::CORDIC_CELLS];

  assign k_ctl[0] = pr_ctl_r;
  assign k_x[0]   = pr_x_r;
  assign k_y[0]   = pr_y_r;
  assign k_z[0]   = pr_z_r;

  generate
    for (gi = 0; gi < vau_pkg::CORDIC_CELLS; gi++) begin : g_cordic
      vau_cordic_cell #(
        .STEP (gi)
      ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ctl_i (k_ctl[gi]),
        .x_i   (k_x[gi]),
        .y_i   (k_y[gi]),
        .z_i   (k_z[gi]),
        .ctl_o (k_ctl[gi+1]),
        .x_o   (k_x[gi+1]),
        .y_o   (k_y[gi+1]),
        .z_o   (k_z[gi+1])
      );
    end
  endgenerate

  // ---- output register: clamp to [0, pi], round half up
  vau_pkg::ctl_t        last_ctl;
  logic signed [ZW-1:0] last_z;
  logic [ZW-1:0]        zc, zr;
  logic [AW-1:0]        angle_nxt;
  logic                 out_valid_r, degen_r;
  logic [AW-1:0]        angle_r;
  logic                 out_free;

  assign last_ctl = k_ctl[vau_pkg::CORDIC_CELLS];
  assign last_z   = k_z[vau_pkg::CORDIC_CELLS];

  always_comb begin
    if (last_z < 0) begin
      zc = '0;
    end else if (unsigned'(last_z) > vau_pkg::PI_Q30) begin
      zc = vau_pkg::PI_Q30;
    end else begin
      zc = unsigned'(last_z);
    end
    zr        = (zc + RND) >> RSH;
    angle_nxt = last_ctl.degen ? '0 : zr[AW-1:0];
  end

  // take a new result when the register is empty or being drained
  assign out_free = !out_valid_r || out_tready;
  // hold the chain only when a finished result would have nowhere to go
  assign en        = out_free || !last_ctl.valid;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= last_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      angle_r <= angle_nxt;
      degen_r <= last_ctl.degen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(angle_r);
  assign out_tuser  = degen_r;

  // ---- checks
  // a zero-length vector always yields angle zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> angle_r == '0)
    else $error("degenerate result with nonzero angle");

  // the angle never exceeds pi
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> angle_r <= PI_OUT[AW-1:0])
    else $error("angle above pi");

  // input backpressure only while a finished result is stuck at the output
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && last_ctl.valid)
    else $error("input stalled without output backpressure");

  // nothing leaves the block right after reset
  assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule

// ----- rtl/core/vau_norm_cell.sv -----
// ----------------------------------------------------------------------------
// vau_norm_cell: one normalization step
// Scale the squared cross length by 4^SHIFT and the dot magnitude by 2^SHIFT
// when both stay below their limits.
// ----------------------------------------------------------------------------
module vau_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  vau_pkg::ctl_t                 ctl_i,
  input  logic [vau_pkg::CRS_W-1:0]     crs_i,
  input  logic [vau_pkg::DMAG_W-1:0]    dmag_i,
  output vau_pkg::ctl_t                 ctl_o,
  output logic [vau_pkg::CRS_W-1:0]     crs_o,
  output logic [vau_pkg::DMAG_W-1:0]    dmag_o
);

  vau_pkg::ctl_t                 ctl_r;
  logic [vau_pkg::CRS_W-1:0]     crs_r, crs_nxt;
  logic [vau_pkg::DMAG_W-1:0]    dmag_r, dmag_nxt;
  logic                          go;

  always_comb begin
    go = ((crs_i >> (62 - 2 * SHIFT)) == '0) && ((dmag_i >> (32 - SHIFT)) == '0);
    crs_nxt  = go ? (crs_i << (2 * SHIFT)) : crs_i;
    dmag_nxt = go ? (dmag_i << SHIFT) : dmag_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crs_r  <= crs_nxt;
      dmag_r <= dmag_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign crs_o  = crs_r;
  assign dmag_o = dmag_r;

endmodule

// ----- rtl/core/vau_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// vau_sqrt_cell: one digit of the integer square root
// Try the root bit 2^(31-STEP); subtract and set it when the remainder allows.
// ----------------------------------------------------------------------------
module vau_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  vau_pkg::ctl_t                 ctl_i,
  input  logic [vau_pkg::CRS_W-1:0]     rem_i,
  input  logic [vau_pkg::CRS_W-1:0]     root_i,
  input  logic [vau_pkg::DMAG_W-1:0]    dmag_i,
  output vau_pkg::ctl_t                 ctl_o,
  output logic [vau_pkg::CRS_W-1:0]     rem_o,
  output logic [vau_pkg::CRS_W-1:0]     root_o,
  output logic [vau_pkg::DMAG_W-1:0]    dmag_o
);

  localparam logic [vau_pkg::CRS_W-1:0] BIT = 64'd1 << (62 - 2 * STEP);

  vau_pkg::ctl_t                 ctl_r;
  logic [vau_pkg::CRS_W-1:0]     rem_r, rem_nxt, root_r, root_nxt, trial;
  logic [vau_pkg::DMAG_W-1:0]    dmag_r;

  always_comb begin
    trial = root_i + BIT;
    if (rem_i >= trial) begin
      rem_nxt  = rem_i - trial;
      root_nxt = (root_i >> 1) + BIT;
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      dmag_r <= dmag_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign dmag_o = dmag_r;

endmodule

// ----- rtl/core/vau_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// vau_cordic_cell: one CORDIC vectoring iteration
// Rotate toward the x axis by atan(2^-STEP) and accumulate the angle.
// ----------------------------------------------------------------------------
module vau_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  vau_pkg::ctl_t                     ctl_i,
  input  logic signed [vau_pkg::XY_W-1:0]   x_i,
  input  logic signed [vau_pkg::XY_W-1:0]   y_i,
  input  logic signed [vau_pkg::Z_W-1:0]    z_i,
  output vau_pkg::ctl_t                     ctl_o,
  output logic signed [vau_pkg::XY_W-1:0]   x_o,
  output logic signed [vau_pkg::XY_W-1:0]   y_o,
  output logic signed [vau_pkg::Z_W-1:0]    z_o
);

  localparam logic signed [vau_pkg::Z_W-1:0] ANG = vau_pkg::atan_q30(STEP);

  vau_pkg::ctl_t                     ctl_r;
  logic signed [vau_pkg::XY_W-1:0]   x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [vau_pkg::Z_W-1:0]    z_r, z_nxt;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (y_i > 0) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule
